// ===== sv/svmm_pkg.sv =====
// ----------------------------------------------------------------------------
// svmm_pkg
// Shared widths, constants and register indexes for the min-max SVPWM block.
// ----------------------------------------------------------------------------
package svmm_pkg;

  localparam int DATA_W  = 16;
  localparam int BUS_W   = 15;
  localparam int PHASE_W = 21;  // phase voltage after offset injection
  localparam int DIV_STAGES = BUS_W;
  localparam int LATENCY = 25;  // accept edge to strobe sample edge

  localparam logic signed [15:0] K_SQRT3_2 = 16'sd28377;
  localparam logic signed [17:0] K_HALF    = 18'sd16384;
  localparam logic [15:0]        K_ONE     = 16'd32768;

  typedef enum logic {
    REG_BUS_VOLTAGE = 1'b0,
    REG_PWM_PERIOD  = 1'b1
  } reg_index_t;

  localparam logic [BUS_W-1:0]  BUS_RESET    = 15'd32767;
  localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd4096;

  typedef logic signed [PHASE_W-1:0] phase_t;

endpackage

// ===== sv/svpwm_min_max_duty.sv =====
// ----------------------------------------------------------------------------
// svpwm_min_max_duty
// Q15 space-vector PWM compare generator with min-max offset injection.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred when start is high and busy is low. busy is
//   always low: a new command may follow in every cycle.
//   Each command gives one result: done is high for exactly one cycle with
//   compare_a/b/c; the receiver must take it then.
//   Throughput: one command per clock.
//   The pipeline holds the divide, one quotient bit per stage over 15
//   stages, plus six stages of transform and injection, one of magnitude
//   and range check and three of centring and scaling.
//   bus_voltage (index 0) and the PWM period (index 1) are written via wr_en/
//   wr_index/wr_data only with no command in flight; the user must ensure it.
//   Reset clears the pipeline valids and restores bus_voltage 32767 and
//   the PWM period 4096; commands in flight are dropped.
// ----------------------------------------------------------------------------
module svpwm_min_max_duty (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] sin_value,
  input  logic signed [15:0] cos_value,
  input  logic signed [15:0] volt_d,
  input  logic signed [15:0] volt_q,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [15:0]        wr_data,
  output logic               done,
  output logic [15:0]        compare_a,
  output logic [15:0]        compare_b,
  output logic [15:0]        compare_c
);

  logic [svmm_pkg::BUS_W-1:0]  bus_voltage;
  logic [svmm_pkg::DATA_W-1:0] period_cnt;
  logic [svmm_pkg::BUS_W-1:0]  bus_eff;
  logic                        ph_vld;
  svmm_pkg::phase_t            phase_a, phase_b, phase_c;
  logic                        vld_b, vld_c;

  assign busy    = 1'b0;
  assign bus_eff = (bus_voltage == '0) ? svmm_pkg::BUS_W'(1) : bus_voltage;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_voltage <= svmm_pkg::BUS_RESET;
      period_cnt  <= svmm_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      case (svmm_pkg::reg_index_t'(wr_index))
        svmm_pkg::REG_BUS_VOLTAGE: bus_voltage <= wr_data[svmm_pkg::BUS_W-1:0];
        svmm_pkg::REG_PWM_PERIOD:  period_cnt  <= wr_data;
        default: ;
      endcase
    end
  end

  svmm_inject u_inject (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start & ~busy),
    .sin_value (sin_value),
    .cos_value (cos_value),
    .volt_d    (volt_d),
    .volt_q    (volt_q),
    .out_vld   (ph_vld),
    .phase_a   (phase_a),
    .phase_b   (phase_b),
    .phase_c   (phase_c)
  );

  svmm_duty_lane u_lane_a (
    .clk (clk), .rst (rst), .in_vld (ph_vld), .phase (phase_a),
    .bus (bus_eff), .period (period_cnt), .out_vld (done), .compare (compare_a)
  );

  svmm_duty_lane u_lane_b (
    .clk (clk), .rst (rst), .in_vld (ph_vld), .phase (phase_b),
    .bus (bus_eff), .period (period_cnt), .out_vld (vld_b), .compare (compare_b)
  );

  svmm_duty_lane u_lane_c (
    .clk (clk), .rst (rst), .in_vld (ph_vld), .phase (phase_c),
    .bus (bus_eff), .period (period_cnt), .out_vld (vld_c), .compare (compare_c)
  );

endmodule

// ===== sv/svmm_inject.sv =====
// ----------------------------------------------------------------------------
// svmm_inject
// Inverse Park, phase voltages and min-max common-mode offset, six stages.
// ----------------------------------------------------------------------------
module svmm_inject (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [15:0]  sin_value,
  input  logic signed [15:0]  cos_value,
  input  logic signed [15:0]  volt_d,
  input  logic signed [15:0]  volt_q,
  output logic                out_vld,
  output svmm_pkg::phase_t    phase_a,
  output svmm_pkg::phase_t    phase_b,
  output svmm_pkg::phase_t    phase_c
);

  logic [4:0] vld;

  // stage 1: products
  logic signed [31:0] p_cd, p_sq, p_sd, p_cq;
  // stage 2
  logic signed [17:0] alpha2, beta2;
  // stage 3
  logic signed [17:0] alpha3, half3;
  logic signed [33:0] rot_prod;
  // stage 4
  logic signed [19:0] alpha4, pb4, pc4;
  // stage 5
  logic signed [19:0] alpha5, pb5, pc5;
  logic signed [20:0] sum5;

  logic signed [18:0] nalpha;
  logic signed [18:0] rot;
  logic signed [19:0] half_x, lo, hi;
  logic signed [21:0] nsum;
  logic signed [20:0] off;

  logic signed [17:0] K_SQRT3_2_X;
  assign K_SQRT3_2_X = {{2{svmm_pkg::K_SQRT3_2[15]}}, svmm_pkg::K_SQRT3_2};

  always_comb begin
    nalpha = -{alpha2[17], alpha2};
    rot    = rot_prod[33:15];
    half_x = {{2{half3[17]}}, half3};
    lo = (alpha4 < pb4) ? alpha4 : pb4;
    hi = (alpha4 > pb4) ? alpha4 : pb4;
    if (lo >= pc4) begin
      lo = pc4;
    end
    if (hi <= pc4) begin
      hi = pc4;
    end
    nsum = -{sum5[20], sum5};
    off  = nsum[21:1];  // floor of -(lo+hi)/2
  end

  always_ff @(posedge clk) begin
    p_cd <= cos_value * volt_d;
    p_sq <= sin_value * volt_q;
    p_sd <= sin_value * volt_d;
    p_cq <= cos_value * volt_q;

    alpha2 <= {p_cd[31], p_cd[31:15]} - {p_sq[31], p_sq[31:15]};
    beta2  <= {p_sd[31], p_sd[31:15]} + {p_cq[31], p_cq[31:15]};

    alpha3   <= alpha2;
    half3    <= nalpha[18:1];
    rot_prod <= beta2 * K_SQRT3_2_X;

    alpha4 <= {{2{alpha3[17]}}, alpha3};
    pb4    <= half_x + {rot[18], rot};
    pc4    <= half_x - {rot[18], rot};

    alpha5 <= alpha4;
    pb5    <= pb4;
    pc5    <= pc4;
    sum5   <= {lo[19], lo} + {hi[19], hi};

    phase_a <= off + {alpha5[19], alpha5};
    phase_b <= off + {pb5[19], pb5};
    phase_c <= off + {pc5[19], pc5};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

endmodule

// ===== sv/svmm_duty_lane.sv =====
// ----------------------------------------------------------------------------
// svmm_duty_lane
// One phase: divide by bus voltage (one quotient bit per stage), centre at
// one half, clamp and scale to compare counts.
// ----------------------------------------------------------------------------
module svmm_duty_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  svmm_pkg::phase_t                 phase,
  input  logic [svmm_pkg::BUS_W-1:0]       bus,
  input  logic [svmm_pkg::DATA_W-1:0]      period,
  output logic                             out_vld,
  output logic [svmm_pkg::DATA_W-1:0]      compare
);

  localparam int N  = svmm_pkg::DIV_STAGES;
  localparam int BW = svmm_pkg::BUS_W;

  logic [N:0]          vld;
  logic [N:0]          neg;
  logic [N:0]          ovf;
  logic [BW-1:0]       rem [0:N];
  logic [BW-1:0]       quo [0:N];
  logic                vld_d, vld_p;
  logic [15:0]         duty;
  logic [31:0]         prod;

  logic [svmm_pkg::PHASE_W-1:0] mag;
  logic [15:0]                  qmag;
  logic signed [16:0]           qs;
  logic signed [17:0]           duty_raw;

  always_comb begin
    mag  = phase[svmm_pkg::PHASE_W-1] ? 21'(-phase) : 21'(phase);
    qmag = ovf[N] ? svmm_pkg::K_ONE : {1'b0, quo[N]};
    qs   = neg[N] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    duty_raw = svmm_pkg::K_HALF - {qs[16], qs};
  end

  always_ff @(posedge clk) begin : div_pipe
    logic [BW:0] t;
    neg[0] <= phase[svmm_pkg::PHASE_W-1];
    // quotient of 2^15 or more once the magnitude reaches the divisor
    ovf[0] <= mag >= {{(svmm_pkg::PHASE_W-BW){1'b0}}, bus};
    rem[0] <= mag[BW-1:0];
    quo[0] <= '0;
    for (int k = 0; k < N; k++) begin
      t = {rem[k], 1'b0};
      if (t >= {1'b0, bus}) begin
        rem[k+1] <= BW'(t - {1'b0, bus});
        quo[k+1] <= {quo[k][BW-2:0], 1'b1};
      end else begin
        rem[k+1] <= t[BW-1:0];
        quo[k+1] <= {quo[k][BW-2:0], 1'b0};
      end
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
    end
    if (duty_raw < 0) begin
      duty <= '0;
    end else if (duty_raw > $signed({2'b00, svmm_pkg::K_ONE})) begin
      duty <= svmm_pkg::K_ONE;
    end else begin
      duty <= duty_raw[15:0];
    end
    prod    <= duty * period;
    // duty is at most one, so the count never exceeds the period
    compare <= prod[30:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_d   <= 1'b0;
      vld_p   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[N-1:0], in_vld};
      vld_d   <= vld[N];
      vld_p   <= vld_d;
      out_vld <= vld_p;
    end
  end

endmodule

// ===== sv/svmm_checker.sv =====
// ----------------------------------------------------------------------------
// svmm_checker
// Port-level checks on transfer latency and result strobe.
// ----------------------------------------------------------------------------
module svmm_sva (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(svmm_pkg::LATENCY) done)
    else $error("result missing after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, svmm_pkg::LATENCY))
    else $error("result without matching transfer");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result straight after reset");

endmodule

bind svpwm_min_max_duty svmm_sva u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
